### rtl/hrht_pkg.sv
// Package for the HTTP response header tokenizer: parse phases, byte classes,
// status codes, character constants and the state and result structs.
// No dependencies.
package hrht_pkg;

  localparam int unsigned LENGTH_LIMIT = 4096;
  localparam int unsigned LEN_W        = 13;

  localparam logic [LEN_W-1:0] LIMIT_MAX   = LEN_W'(LENGTH_LIMIT);
  localparam logic [LEN_W-1:0] LIMIT_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1024);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_VERSION = 4'd1,
    PH_GAP1    = 4'd2,
    PH_CODE    = 4'd3,
    PH_GAP2    = 4'd4,
    PH_REASON  = 4'd5,
    PH_LINE    = 4'd6,
    PH_NAME    = 4'd7,
    PH_VSKIP   = 4'd8,
    PH_VALUE   = 4'd9,
    PH_DONE    = 4'd10,
    PH_ERR     = 4'd11,
    PH_LONG    = 4'd12
  } phase_e;

  typedef enum logic [2:0] {
    CLS_VERSION = 3'd0,
    CLS_CODE    = 3'd1,
    CLS_REASON  = 3'd2,
    CLS_NAME    = 3'd3,
    CLS_VALUE   = 3'd4,
    CLS_SEP     = 3'd5,
    CLS_BREAK   = 3'd6,
    CLS_BODY    = 3'd7
  } byte_class_e;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_FORMAT   = 2'd2,
    ST_LONG     = 2'd3
  } parse_status_e;

  // Progress through a line ending: none, CR, CRLF, CRLFCR.
  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_CR     = 2'd1,
    BR_CRLF   = 2'd2,
    BR_CRLFCR = 2'd3
  } break_run_e;

  typedef struct packed {
    phase_e           phase;
    logic [LEN_W-1:0] token_length;
    logic [LEN_W-1:0] head_count;
    break_run_e       break_run;
    logic [7:0]       line_counter;
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0] head_length;
    parse_status_e    parse_status;
    logic [7:0]       line_number;
    logic             token_closed;
    logic             token_first;
    byte_class_e      byte_class;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:        PH_IDLE,
    token_length: '0,
    head_count:   '0,
    break_run:    BR_NONE,
    line_counter: '0
  };

endpackage

### rtl/hrht_cfg.sv
// Length limit register of the HTTP response header tokenizer.
// Clamps each written value into the legal range. Depends on hrht_pkg.
module hrht_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hrht_pkg::LEN_W-1:0] cfg_data_i,
  output logic [hrht_pkg::LEN_W-1:0] limit_o
);

  logic [hrht_pkg::LEN_W-1:0] limit_q;
  logic [hrht_pkg::LEN_W-1:0] limit_d;

  always_comb begin
    if (cfg_data_i < hrht_pkg::LIMIT_MIN) begin
      limit_d = hrht_pkg::LIMIT_MIN;
    end else if (cfg_data_i > hrht_pkg::LIMIT_MAX) begin
      limit_d = hrht_pkg::LIMIT_MAX;
    end else begin
      limit_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hrht_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= limit_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign limit_o     = limit_q;

endmodule

### rtl/hrht_step.sv
// Per-byte parse step of the HTTP response header tokenizer: from the
// current state and one byte, the next state and the byte's result.
// Pure combinational logic. Depends on hrht_pkg.
module hrht_step (
  input  logic [7:0]                 data_byte_i,
  input  logic                       message_start_i,
  input  logic [hrht_pkg::LEN_W-1:0] limit_i,
  input  hrht_pkg::state_t           state_i,
  output hrht_pkg::state_t           state_o,
  output hrht_pkg::result_t          result_o
);

  logic                       brk;
  logic                       blank;
  logic                       colon;
  logic                       grow;
  hrht_pkg::state_t           st;
  hrht_pkg::byte_class_e      cls;
  logic                       first;
  logic                       closed;
  logic [hrht_pkg::LEN_W-1:0] tok_next;

  assign brk   = (data_byte_i == hrht_pkg::CH_CR) || (data_byte_i == hrht_pkg::CH_LF);
  assign blank = (data_byte_i == hrht_pkg::CH_SPACE) || (data_byte_i == hrht_pkg::CH_TAB);
  assign colon = (data_byte_i == hrht_pkg::CH_COLON);

  always_comb begin
    st       = message_start_i ? hrht_pkg::STATE_RESET : state_i;
    cls      = hrht_pkg::CLS_BODY;
    first    = 1'b0;
    closed   = 1'b0;
    grow     = 1'b0;
    tok_next = st.token_length;

    if (st.phase != hrht_pkg::PH_DONE && st.phase != hrht_pkg::PH_ERR &&
        st.phase != hrht_pkg::PH_LONG) begin
      st.head_count = st.head_count + 1'b1;
      if (st.head_count > limit_i) begin
        st.phase = hrht_pkg::PH_LONG;
      end
    end

    case (st.phase)
      hrht_pkg::PH_IDLE: begin
        if (brk || blank) begin
          st.phase = hrht_pkg::PH_ERR;
        end else begin
          cls = hrht_pkg::CLS_VERSION; first = 1'b1; tok_next = '0;
          st.phase = hrht_pkg::PH_VERSION; grow = 1'b1;
        end
      end
      hrht_pkg::PH_VERSION: begin
        if (brk) begin
          st.phase = hrht_pkg::PH_ERR;
        end else if (blank) begin
          cls = hrht_pkg::CLS_SEP; closed = 1'b1; st.phase = hrht_pkg::PH_GAP1;
        end else begin
          cls = hrht_pkg::CLS_VERSION; grow = 1'b1;
        end
      end
      hrht_pkg::PH_GAP1: begin
        if (brk) begin
          st.phase = hrht_pkg::PH_ERR;
        end else if (blank) begin
          cls = hrht_pkg::CLS_SEP;
        end else begin
          cls = hrht_pkg::CLS_CODE; first = 1'b1; tok_next = '0;
          st.phase = hrht_pkg::PH_CODE; grow = 1'b1;
        end
      end
      hrht_pkg::PH_CODE: begin
        if (brk) begin
          st.phase = hrht_pkg::PH_ERR;
        end else if (blank) begin
          cls = hrht_pkg::CLS_SEP; closed = 1'b1; st.phase = hrht_pkg::PH_GAP2;
        end else begin
          cls = hrht_pkg::CLS_CODE; grow = 1'b1;
        end
      end
      hrht_pkg::PH_GAP2: begin
        if (brk) begin
          st.phase = hrht_pkg::PH_ERR;
        end else if (blank) begin
          cls = hrht_pkg::CLS_SEP;
        end else begin
          cls = hrht_pkg::CLS_REASON; first = 1'b1; tok_next = '0;
          st.phase = hrht_pkg::PH_REASON; grow = 1'b1;
        end
      end
      hrht_pkg::PH_REASON: begin
        if (brk) begin
          cls = hrht_pkg::CLS_BREAK; closed = 1'b1; st.phase = hrht_pkg::PH_LINE;
          st.break_run = (data_byte_i == hrht_pkg::CH_CR) ? hrht_pkg::BR_CR
                                                           : hrht_pkg::BR_NONE;
        end else begin
          cls = hrht_pkg::CLS_REASON; grow = 1'b1;
        end
      end
      hrht_pkg::PH_LINE: begin
        if (brk) begin
          if (data_byte_i == hrht_pkg::CH_LF && st.break_run == hrht_pkg::BR_CR) begin
            st.break_run = hrht_pkg::BR_CRLF; cls = hrht_pkg::CLS_BREAK;
          end else if (data_byte_i == hrht_pkg::CH_CR &&
                       st.break_run == hrht_pkg::BR_CRLF) begin
            st.break_run = hrht_pkg::BR_CRLFCR; cls = hrht_pkg::CLS_BREAK;
          end else if (data_byte_i == hrht_pkg::CH_LF &&
                       st.break_run == hrht_pkg::BR_CRLFCR) begin
            cls = hrht_pkg::CLS_BREAK; st.phase = hrht_pkg::PH_DONE;
          end else begin
            st.phase = hrht_pkg::PH_ERR;
          end
        end else if (st.break_run == hrht_pkg::BR_CRLFCR) begin
          st.phase = hrht_pkg::PH_ERR;
        end else begin
          st.break_run = hrht_pkg::BR_NONE;
          if (st.line_counter != 8'hFF) begin
            st.line_counter = st.line_counter + 1'b1;
          end
          if (colon) begin
            cls = hrht_pkg::CLS_SEP; st.phase = hrht_pkg::PH_VSKIP;
          end else begin
            cls = hrht_pkg::CLS_NAME; first = 1'b1; st.phase = hrht_pkg::PH_NAME;
          end
        end
      end
      hrht_pkg::PH_NAME: begin
        if (brk) begin
          st.phase = hrht_pkg::PH_ERR;
        end else if (colon) begin
          cls = hrht_pkg::CLS_SEP; closed = 1'b1; st.phase = hrht_pkg::PH_VSKIP;
        end else begin
          cls = hrht_pkg::CLS_NAME;
        end
      end
      hrht_pkg::PH_VSKIP: begin
        if (brk) begin
          cls = hrht_pkg::CLS_BREAK; st.phase = hrht_pkg::PH_LINE;
          st.break_run = (data_byte_i == hrht_pkg::CH_CR) ? hrht_pkg::BR_CR
                                                           : hrht_pkg::BR_NONE;
        end else if (blank || colon) begin
          cls = hrht_pkg::CLS_SEP;
        end else begin
          cls = hrht_pkg::CLS_VALUE; first = 1'b1; st.phase = hrht_pkg::PH_VALUE;
        end
      end
      hrht_pkg::PH_VALUE: begin
        if (brk) begin
          cls = hrht_pkg::CLS_BREAK; closed = 1'b1; st.phase = hrht_pkg::PH_LINE;
          st.break_run = (data_byte_i == hrht_pkg::CH_CR) ? hrht_pkg::BR_CR
                                                           : hrht_pkg::BR_NONE;
        end else begin
          cls = hrht_pkg::CLS_VALUE;
        end
      end
      default: begin
      end
    endcase

    // A status token that reaches the limit is a format error.
    if (grow) begin
      tok_next = tok_next + 1'b1;
      if (tok_next >= limit_i) begin
        st.phase = hrht_pkg::PH_ERR;
      end
    end
    st.token_length = tok_next;

    result_o.line_number  = st.line_counter;
    result_o.head_length  = '0;
    result_o.parse_status = hrht_pkg::ST_BUSY;
    result_o.byte_class   = cls;
    result_o.token_first  = first;
    result_o.token_closed = closed;
    if (st.phase == hrht_pkg::PH_DONE) begin
      result_o.parse_status = hrht_pkg::ST_COMPLETE;
      result_o.head_length  = st.head_count;
    end else if (st.phase == hrht_pkg::PH_ERR || st.phase == hrht_pkg::PH_LONG) begin
      result_o.parse_status = (st.phase == hrht_pkg::PH_ERR) ? hrht_pkg::ST_FORMAT
                                                             : hrht_pkg::ST_LONG;
      result_o.byte_class   = hrht_pkg::CLS_BODY;
      result_o.token_first  = 1'b0;
      result_o.token_closed = 1'b0;
    end

    state_o = st;
  end

endmodule

### rtl/http_response_header_tokenizer.sv
// Top level of the HTTP response header tokenizer: input register, parse
// state, result register and stream handshakes.
// Depends on hrht_pkg, hrht_cfg and hrht_step.
//
// Usage: response bytes enter on the s_axis channel, one beat per byte;
// tuser marks the first byte of a new response and clears the parse state
// before that byte is taken. Every input beat yields exactly one result beat
// on m_axis with the byte class, token start and end flags, header line
// number, parse status and, once the blank line is seen, the header length.
// The cfg channel writes the length limit (2 to 4096, clamped); write it
// only while no byte is in flight. It is always ready.
// The byte waits in the input register; when the result register is free or
// drains, the parse step writes the result register and the parse state
// together. Throughput is one byte per cycle while the receiver takes results,
// set by the single parse-state update loop.
// Reset clears the parse state to "before the status line", empties both
// registers and sets the limit to 1024. When the receiver stalls, the result
// register holds its beat, the input register still takes one more byte,
// and s_axis_tready then drops until the result is taken.
module http_response_header_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] message_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] byte_class, [3] token_first, [4] token_closed, [12:5] line_number,
  // [14:13] parse_status, [27:15] head_length, [31:28] zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [hrht_pkg::LEN_W-1:0] cfg_data_i
);

  logic [hrht_pkg::LEN_W-1:0] limit;
  logic                       in_valid_q;
  logic [7:0]                 byte_q;
  logic                       start_q;
  hrht_pkg::state_t           state_q;
  hrht_pkg::state_t           state_d;
  hrht_pkg::result_t          result_d;
  hrht_pkg::result_t          result_q;
  logic                       out_valid_q;
  logic                       advance;

  hrht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .limit_o     (limit)
  );

  hrht_step u_step (
    .data_byte_i     (byte_q),
    .message_start_i (start_q),
    .limit_i         (limit),
    .state_i         (state_q),
    .state_o         (state_d),
    .result_o        (result_d)
  );

  // The held byte moves on whenever the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      byte_q  <= s_axis_tdata;
      start_q <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrht_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, result_q};

endmodule
